/* hw/rtl/cfl_pkg.sv */
// cfl_pkg: request/result types, command and register codes, block size helper
// shared by the chroma-from-luma predictor top level and its port checker
// no dependencies
package cfl_pkg;

    localparam int LUMA_SIDE_DEF = 128;
    localparam int MAX_BLOCK_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_COMPUTE  = 2'd1;
    localparam logic [1:0] CMD_PREDICT  = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSAMPLE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSAMPLE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] row;
        logic [6:0] col;
        logic [7:0] sample;
    } t_req;

    typedef struct packed {
        logic [7:0]  value;
        logic [10:0] average;
        logic        status;
    } t_res;

    function automatic logic [2:0] f_side_log2(input logic [2:0] lg, input logic [2:0] max_lg);
        logic [2:0] v;
        v = (lg < 3'd2) ? 3'd2 : lg;
        if (v > max_lg) begin
            v = max_lg;
        end
        return v;
    endfunction

endpackage

/* hw/rtl/chroma_from_luma_predictor_top.sv */
// chroma_from_luma_predictor_top: luma store, tap sequencer with shared accumulator,
// block average and prediction datapath
// depends on cfl_pkg
//
// A load request writes one luma sample. A compute request walks
// the chroma block reading one luma sample per cycle from the luma memory
// through one shared accumulator, T luma samples in all, with
// T = 2^(width_log2 + height_log2) * (1 + subsample_x) * (1 + subsample_y), the log2
// sizes taken after clamping to the allowed block sizes, and the result follows in the
// cycle busy falls. A predict request reads its 1 to 4 luma samples the same way, then
// multiplies and rounds. With a bad luma extent compute and predict do no reads and the
// result shows in the cycle after the request. Each result is shown on o_res for one
// cycle with o_strobe high; the receiver cannot stall it.
// The luma memory has no reset and needs no clearing.
module chroma_from_luma_predictor_top #(
    parameter int LUMA_SIDE = cfl_pkg::LUMA_SIDE_DEF,
    parameter int MAX_BLOCK = cfl_pkg::MAX_BLOCK_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           start,
    input  cfl_pkg::t_req                  i_req,
    output logic                           busy,
    output logic                           o_strobe,
    output cfl_pkg::t_res                  o_res
);
    import cfl_pkg::*;

    localparam int DEPTH  = LUMA_SIDE * LUMA_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int LW     = $clog2(LUMA_SIDE);
    localparam int MAX_LG = $clog2(MAX_BLOCK + 1) - 1;
    localparam int ACC_W  = 11 + 2 * MAX_LG;
    localparam logic [7:0] SIDE   = 8'(LUMA_SIDE);
    localparam logic [2:0] MAXLG3 = 3'(MAX_LG);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_AVG,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state;

    logic [2:0]  r_width_log2;
    logic [2:0]  r_height_log2;
    logic [7:0]  r_luma_width;
    logic [7:0]  r_luma_height;
    logic        r_sub_x;
    logic        r_sub_y;
    logic [5:0]  r_alpha;

    logic             r_is_cmp;
    logic [7:0]       r_dc;
    logic [6:0]       r_ci;
    logic [6:0]       r_cj;
    logic             r_dy;
    logic             r_dx;
    logic             r_rd_vld;
    logic [7:0]       r_rd_data;
    logic [ACC_W-1:0] r_acc;
    logic [10:0]      r_block_avg;
    logic signed [17:0] r_prod;
    logic             r_strobe;
    t_res             r_res;

    logic [7:0] mem [DEPTH];

    logic             accept;
    logic [2:0]       wl;
    logic [2:0]       hl;
    logic [7:0]       lw_lim;
    logic [7:0]       lh_lim;
    logic [7:0]       stx;
    logic [7:0]       sty;
    logic             ext_ok;
    logic             cj_last;
    logic             ci_last;
    logic             grp_last;
    logic             tap_last;
    logic [7:0]       y0;
    logic [7:0]       x0;
    logic [7:0]       y_base;
    logic [7:0]       x_base;
    logic [LW-1:0]    ly;
    logic [LW-1:0]    lx;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             load_ok;
    logic [1:0]       shift;
    logic [ACC_W-1:0] addend;
    logic [3:0]       n;
    logic [ACC_W-1:0] avg_sum;
    logic [10:0]      avg;
    logic signed [11:0] diff;
    logic signed [17:0] prod_n;
    logic [17:0]      mag;
    logic [11:0]      q;
    logic signed [13:0] v;
    logic [7:0]       clip;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign wl     = f_side_log2(r_width_log2, MAXLG3);
    assign hl     = f_side_log2(r_height_log2, MAXLG3);
    assign lw_lim = (r_luma_width > SIDE) ? SIDE : r_luma_width;
    assign lh_lim = (r_luma_height > SIDE) ? SIDE : r_luma_height;
    assign stx    = r_sub_x ? 8'd2 : 8'd1;
    assign sty    = r_sub_y ? 8'd2 : 8'd1;
    assign ext_ok = (lw_lim >= stx) && (lh_lim >= sty);

    assign cj_last  = (r_cj == 7'((8'd1 << wl) - 8'd1));
    assign ci_last  = (r_ci == 7'((8'd1 << hl) - 8'd1));
    assign grp_last = (r_dx == r_sub_x) && (r_dy == r_sub_y);
    assign tap_last = grp_last && (!r_is_cmp || (cj_last && ci_last));

    // luma group origin, clamped into the luma extent
    assign y0     = r_sub_y ? {r_ci, 1'b0} : {1'b0, r_ci};
    assign x0     = r_sub_x ? {r_cj, 1'b0} : {1'b0, r_cj};
    assign y_base = ({1'b0, y0} + {1'b0, sty} > {1'b0, lh_lim}) ? lh_lim - sty : y0;
    assign x_base = ({1'b0, x0} + {1'b0, stx} > {1'b0, lw_lim}) ? lw_lim - stx : x0;
    assign ly     = LW'(y_base + {7'd0, r_dy});
    assign lx     = LW'(x_base + {7'd0, r_dx});
    assign rd_addr = AW'(ly) * AW'(LUMA_SIDE) + AW'(lx);

    assign load_ok = ({1'b0, i_req.row} < SIDE) && ({1'b0, i_req.col} < SIDE);
    assign wr_addr = AW'(i_req.row) * AW'(LUMA_SIDE) + AW'(i_req.col);

    // shared accumulator input, scaled to three fractional bits
    assign shift  = 2'd3 - {1'b0, r_sub_x} - {1'b0, r_sub_y};
    assign addend = ACC_W'(r_rd_data) << shift;

    assign n       = {1'b0, wl} + {1'b0, hl};
    assign avg_sum = r_acc + (ACC_W'(1) << (n - 4'd1));
    assign avg     = 11'(avg_sum >> n);

    assign diff   = $signed({1'b0, r_acc[10:0]}) - $signed({1'b0, r_block_avg});
    assign prod_n = 18'($signed(r_alpha)) * 18'(diff);

    assign mag  = r_prod[17] ? 18'(-r_prod) : 18'(r_prod);
    assign q    = 12'((mag + 18'd32) >> 6);
    assign v    = $signed({6'd0, r_dc}) +
                  (r_prod[17] ? -$signed({2'b0, q}) : $signed({2'b0, q}));
    assign clip = (v < 14'sd0) ? 8'd0 : ((v > 14'sd255) ? 8'd255 : v[7:0]);

    // luma memory
    always_ff @(posedge i_clk) begin
        if (accept && (i_req.cmd == CMD_LOAD) && load_ok) begin
            mem[wr_addr] <= i_req.sample;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_width_log2  <= 3'd2;
            r_height_log2 <= 3'd2;
            r_luma_width  <= 8'd8;
            r_luma_height <= 8'd8;
            r_sub_x       <= 1'b1;
            r_sub_y       <= 1'b1;
            r_alpha       <= 6'd0;
            r_block_avg   <= 11'd0;
            r_strobe      <= 1'b0;
            r_rd_vld      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_rd_vld <= (r_state == S_WALK);

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH_LOG2:  r_width_log2  <= i_cfg_data[2:0];
                    REG_HEIGHT_LOG2: r_height_log2 <= i_cfg_data[2:0];
                    REG_LUMA_WIDTH:  r_luma_width  <= i_cfg_data;
                    REG_LUMA_HEIGHT: r_luma_height <= i_cfg_data;
                    REG_SUBSAMPLE_X: r_sub_x       <= i_cfg_data[0];
                    REG_SUBSAMPLE_Y: r_sub_y       <= i_cfg_data[0];
                    REG_ALPHA:       r_alpha       <= i_cfg_data[5:0];
                    default: ;
                endcase
            end

            if (r_rd_vld) begin
                r_acc <= r_acc + addend;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept && ((i_req.cmd == CMD_COMPUTE) || (i_req.cmd == CMD_PREDICT))) begin
                        if (!ext_ok) begin
                            r_strobe <= 1'b1;
                            r_res.status <= 1'b1;
                            if (i_req.cmd == CMD_COMPUTE) begin
                                r_res.value   <= 8'd0;
                                r_res.average <= 11'd0;
                            end else begin
                                r_res.value   <= i_req.sample;
                                r_res.average <= r_block_avg;
                            end
                        end else begin
                            r_is_cmp <= (i_req.cmd == CMD_COMPUTE);
                            r_dc     <= i_req.sample;
                            r_ci     <= (i_req.cmd == CMD_COMPUTE) ? 7'd0 : i_req.row;
                            r_cj     <= (i_req.cmd == CMD_COMPUTE) ? 7'd0 : i_req.col;
                            r_dy     <= 1'b0;
                            r_dx     <= 1'b0;
                            r_acc    <= '0;
                            r_state  <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (r_dx != r_sub_x) begin
                        r_dx <= 1'b1;
                    end else begin
                        r_dx <= 1'b0;
                        if (r_dy != r_sub_y) begin
                            r_dy <= 1'b1;
                        end else begin
                            r_dy <= 1'b0;
                            if (!cj_last) begin
                                r_cj <= r_cj + 7'd1;
                            end else begin
                                r_cj <= 7'd0;
                                r_ci <= r_ci + 7'd1;
                            end
                        end
                    end
                    if (tap_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= r_is_cmp ? S_AVG : S_MUL;
                end
                S_AVG: begin
                    r_block_avg   <= avg;
                    r_res.value   <= 8'd0;
                    r_res.average <= avg;
                    r_res.status  <= 1'b0;
                    r_strobe      <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_MUL: begin
                    r_prod  <= prod_n;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res.value   <= clip;
                    r_res.average <= r_block_avg;
                    r_res.status  <= 1'b0;
                    r_strobe      <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* hw/rtl/cfl_checker.sv */
// cfl_checker: port-level assertions on the chroma-from-luma predictor top level
// and the bind that attaches it
// depends on cfl_pkg
module cfl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input cfl_pkg::t_req i_req,
    input logic          busy,
    input logic          o_strobe,
    input cfl_pkg::t_res o_res
);
    import cfl_pkg::*;

    // a load request finishes at once and gives no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.cmd == CMD_LOAD) |=> !busy && !o_strobe)
        else $error("load request caused busy or a result");

    // a request that stops being busy always hands out its result
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy fell without a result");

    // busy only starts from an accepted request
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // no result without an accepted request or work in flight
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy) || $past(busy))
        else $error("result without a request");

    // a bad-extent result with a nonzero average comes straight from an idle request
    a_cmp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.status && (o_res.average != 11'd0) |-> $past(busy) == 1'b0)
        else $error("bad-extent result with average from a running request");

endmodule

bind chroma_from_luma_predictor_top cfl_checker u_cfl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .i_req      (i_req),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_res      (o_res)
);

/* tb/testbench.sv */
// testbench: self-checking bench for chroma_from_luma_predictor_top, with its own cfl predictor
// in a small scoreboard class and plain tasks driving the request and register ports
// depends on cfl_pkg and chroma_from_luma_predictor_top
`timescale 1ns / 100ps

module testbench;
    import cfl_pkg::*;

    class cfl_scoreboard;
        localparam int SIDE = LUMA_SIDE_DEF;
        localparam int MAX_LG = $clog2(MAX_BLOCK_DEF);

        logic [7:0]  luma_mem [SIDE*SIDE];
        logic [2:0]  wl_reg;
        logic [2:0]  hl_reg;
        logic [7:0]  lw_reg;
        logic [7:0]  lh_reg;
        logic        sx_reg;
        logic        sy_reg;
        logic [5:0]  alpha_reg;
        logic [10:0] avg_reg;
        t_res        awaited [$];
        int          fault_count;

        function new();
            wl_reg = 3'd2;
            hl_reg = 3'd2;
            lw_reg = 8'd8;
            lh_reg = 8'd8;
            sx_reg = 1'b1;
            sy_reg = 1'b1;
            alpha_reg = '0;
            avg_reg = '0;
            fault_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH_LOG2:  wl_reg = data[2:0];
                REG_HEIGHT_LOG2: hl_reg = data[2:0];
                REG_LUMA_WIDTH:  lw_reg = data;
                REG_LUMA_HEIGHT: lh_reg = data;
                REG_SUBSAMPLE_X: sx_reg = data[0];
                REG_SUBSAMPLE_Y: sy_reg = data[0];
                REG_ALPHA:       alpha_reg = data[5:0];
                default: ;
            endcase
        endfunction

        function int side_lg(logic [2:0] lg);
            int v;
            v = (lg < 3'd2) ? 2 : int'(lg);
            if (v > MAX_LG) v = MAX_LG;
            return v;
        endfunction

        function int clamp_extent(logic [7:0] v);
            return (int'(v) > SIDE) ? SIDE : int'(v);
        endfunction

        function bit extent_ok();
            return clamp_extent(lw_reg) >= (1 << int'(sx_reg)) &&
                   clamp_extent(lh_reg) >= (1 << int'(sy_reg));
        endfunction

        // scaled luma group of one chroma position, clamped into the luma extent
        function int group_scaled(int r, int c);
            int sx, sy, lw, lh, y, x, total;
            sx = sx_reg;
            sy = sy_reg;
            lw = clamp_extent(lw_reg);
            lh = clamp_extent(lh_reg);
            y = r << sy;
            x = c << sx;
            total = 0;
            if (y + (1 << sy) > lh) y = lh - (1 << sy);
            if (x + (1 << sx) > lw) x = lw - (1 << sx);
            for (int dy = 0; dy <= sy; dy++) begin
                for (int dx = 0; dx <= sx; dx++) begin
                    total += int'(luma_mem[(y + dy) * SIDE + x + dx]);
                end
            end
            return total << (3 - sx - sy);
        endfunction

        function void take_request(t_req r);
            t_res e;
            int wlg, hlg, n, sum, a, prod, rnd, v;
            e = '0;
            case (r.cmd)
                CMD_LOAD: begin
                    luma_mem[int'(r.row) * SIDE + int'(r.col)] = r.sample;
                end
                CMD_COMPUTE: begin
                    if (!extent_ok()) begin
                        e.status = 1'b1;
                    end else begin
                        wlg = side_lg(wl_reg);
                        hlg = side_lg(hl_reg);
                        n = wlg + hlg;
                        sum = 0;
                        for (int i = 0; i < (1 << hlg); i++) begin
                            for (int j = 0; j < (1 << wlg); j++) begin
                                sum += group_scaled(i, j);
                            end
                        end
                        avg_reg = 11'((sum + (1 << (n - 1))) >> n);
                        e.average = avg_reg;
                    end
                    awaited.push_back(e);
                end
                CMD_PREDICT: begin
                    e.average = avg_reg;
                    if (!extent_ok()) begin
                        e.value = r.sample;
                        e.status = 1'b1;
                    end else begin
                        a = $signed(alpha_reg);
                        prod = a * (group_scaled(int'(r.row), int'(r.col)) - int'(avg_reg));
                        rnd = (prod >= 0) ? ((prod + 32) >>> 6) : -((-prod + 32) >>> 6);
                        v = int'(r.sample) + rnd;
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                        e.value = 8'(v);
                    end
                    awaited.push_back(e);
                end
                default: ;
            endcase
        endfunction

        function void note_fault(string what, t_res e, t_res got);
            fault_count++;
            if (fault_count <= 10) begin
                $display("cfl: %s: expected value %0d average %0d status %0d,", what,
                         e.value, e.average, e.status,
                         " got value %0d average %0d status %0d",
                         got.value, got.average, got.status);
            end
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (awaited.size() == 0) begin
                note_fault("result with nothing pending", '0, got);
                return;
            end
            e = awaited.pop_front();
            if (got.value !== e.value || got.average !== e.average || got.status !== e.status) begin
                note_fault("mismatch", e, got);
            end
        endfunction

        function void close_out();
            if (awaited.size() != 0) begin
                $display("cfl: %0d results never arrived", awaited.size());
                fault_count += awaited.size();
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 30_000_000;
    localparam int REGION      = 16;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    t_req                  i_req = '0;
    logic                  busy;
    logic                  o_strobe;
    t_res                  o_res;

    int            idle_pct = 34;
    int            cycle_count = 0;
    cfl_scoreboard sb;

    chroma_from_luma_predictor_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(o_res);
        end
    end

    task automatic push_request(input logic [1:0] cmd, input int row, input int col,
                                input int sample);
        t_req r;
        r.cmd = cmd;
        r.row = 7'(row);
        r.col = 7'(col);
        r.sample = 8'(sample);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.take_request(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input logic [7:0] wl, input logic [7:0] hl, input logic [7:0] lw,
                                 input logic [7:0] lh, input logic [7:0] sx, input logic [7:0] sy,
                                 input logic [7:0] alpha);
        write_reg(REG_WIDTH_LOG2, wl);
        write_reg(REG_HEIGHT_LOG2, hl);
        write_reg(REG_LUMA_WIDTH, lw);
        write_reg(REG_LUMA_HEIGHT, lh);
        write_reg(REG_SUBSAMPLE_X, sx);
        write_reg(REG_SUBSAMPLE_Y, sy);
        write_reg(REG_ALPHA, alpha);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        int wl_raw, hl_raw, wl_eff, hl_eff, pick, row, col;
        logic [7:0] lw, lh;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_setting(8'd2, 8'd2, 8'd8, 8'd8, 8'd1, 8'd1, 8'd0);
        // luma reads stay inside this region and the corner patches
        for (int r = 0; r < REGION; r++) begin
            for (int c = 0; c < REGION; c++) begin
                push_request(CMD_LOAD, r, c, $urandom_range(255));
            end
        end
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                push_request(CMD_LOAD, 126 + r, c, $urandom_range(255));
                push_request(CMD_LOAD, r, 126 + c, $urandom_range(255));
                push_request(CMD_LOAD, 126 + r, 126 + c, $urandom_range(255));
            end
        end
        wait_idle();

        apply_setting(8'd2, 8'd2, 8'd8, 8'd8, 8'd1, 8'd1, 8'd16);
        push_request(CMD_COMPUTE, 0, 0, 0);
        push_request(CMD_PREDICT, 0, 0, 0);
        push_request(CMD_PREDICT, 127, 127, 255);
        push_request(CMD_RESERVED, 127, 127, 255);
        push_request(CMD_LOAD, 0, 0, 255);
        push_request(CMD_PREDICT, 0, 0, 128);
        wait_idle();

        // luma extent saturates at the store side
        apply_setting(8'd2, 8'd2, 8'd255, 8'd255, 8'd1, 8'd1, 8'h08);
        push_request(CMD_COMPUTE, 0, 0, 0);
        push_request(CMD_PREDICT, 127, 0, 50);
        push_request(CMD_PREDICT, 0, 127, 60);
        push_request(CMD_PREDICT, 127, 127, 70);
        wait_idle();

        apply_setting(8'd6, 8'd6, 8'd16, 8'd16, 8'd0, 8'd0, 8'h30);
        push_request(CMD_COMPUTE, 0, 0, 0);
        push_request(CMD_PREDICT, 63, 63, 255);
        push_request(CMD_PREDICT, 0, 127, 0);
        wait_idle();

        apply_setting(8'd0, 8'd7, 8'd255, 8'd16, 8'd1, 8'd0, 8'h20);
        push_request(CMD_COMPUTE, 0, 0, 0);
        push_request(CMD_PREDICT, 127, 0, 200);
        wait_idle();
        apply_setting(8'hF8, 8'hFF, 8'd255, 8'd255, 8'hFF, 8'hFE, 8'hDF);
        push_request(CMD_PREDICT, 5, 3, 10);
        push_request(CMD_PREDICT, 0, 0, 255);
        wait_idle();

        // luma extent too small for the subsample step, then a single-sample luma extent that just fits
        apply_setting(8'd3, 8'd3, 8'd1, 8'd8, 8'd1, 8'd1, 8'h10);
        push_request(CMD_COMPUTE, 0, 0, 0);
        push_request(CMD_PREDICT, 1, 1, 77);
        wait_idle();
        apply_setting(8'd3, 8'd3, 8'd8, 8'd0, 8'd0, 8'd0, 8'h08);
        push_request(CMD_COMPUTE, 0, 0, 0);
        push_request(CMD_PREDICT, 2, 2, 33);
        wait_idle();
        apply_setting(8'd2, 8'd2, 8'd1, 8'd1, 8'd0, 8'd0, 8'h3F);
        push_request(CMD_COMPUTE, 0, 0, 0);
        push_request(CMD_PREDICT, 127, 127, 9);
        wait_idle();

        apply_setting(8'd6, 8'd6, 8'd16, 8'd16, 8'd1, 8'd1, 8'h0F);
        push_request(CMD_COMPUTE, 0, 0, 0);
        push_request(CMD_PREDICT, 31, 31, 100);
        wait_idle();

        for (int seg = 0; seg < 20; seg++) begin
            idle_pct = (seg < 7) ? 34 : (seg < 14) ? 64 : 0;
            wl_raw = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(3);
            hl_raw = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(3);
            // luma extent stays inside the loaded region
            case ($urandom_range(3))
                0: lw = 8'($urandom_range(REGION));
                1: lw = 8'($urandom_range(REGION, 1));
                2: lw = 8'(REGION);
                default: lw = 8'($urandom_range(3));
            endcase
            case ($urandom_range(3))
                0: lh = 8'($urandom_range(REGION));
                1: lh = 8'($urandom_range(REGION, 1));
                2: lh = 8'(REGION);
                default: lh = 8'($urandom_range(3));
            endcase
            apply_setting({5'($urandom_range(31)), 3'(wl_raw)},
                          {5'($urandom_range(31)), 3'(hl_raw)},
                          lw, lh, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
            wl_eff = sb.side_lg(3'(wl_raw));
            hl_eff = sb.side_lg(3'(hl_raw));
            push_request(CMD_COMPUTE, $urandom_range(127), $urandom_range(127),
                         $urandom_range(255));
            for (int k = 0; k < 6; k++) begin
                pick = $urandom_range(99);
                if ($urandom_range(3) != 0) begin
                    row = $urandom_range((1 << hl_eff) - 1);
                    col = $urandom_range((1 << wl_eff) - 1);
                end else begin
                    row = $urandom_range(127);
                    col = $urandom_range(127);
                end
                if (pick < 60) begin
                    push_request(CMD_PREDICT, row, col, $urandom_range(255));
                end else if (pick < 80) begin
                    push_request(CMD_LOAD, row, col, $urandom_range(255));
                end else if (pick < 93) begin
                    push_request(CMD_COMPUTE, row, col, $urandom_range(255));
                end else begin
                    push_request(CMD_RESERVED, row, col, $urandom_range(255));
                end
            end
            wait_idle();
        end

        start <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.close_out();
        if (sb.fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cfl_pkg.sv
hw/rtl/chroma_from_luma_predictor_top.sv
hw/rtl/cfl_checker.sv
tb/testbench.sv
